### sv/otwl_pkg.sv
// Shared types and constants for the one-touch window lift controller.
package otwl_pkg;

  typedef struct packed {
    logic tick;
    logic up_local;
    logic down_local;
    logic up_remote;
    logic down_remote;
    logic close_req;
    logic auth_level;
  } in_item_t;

  typedef struct packed {
    logic       up_drive;
    logic       down_drive;
    logic       auth_drive;
    logic [2:0] window_mode;
    logic [1:0] auth_mode;
    logic [1:0] sequence_phase;
  } out_item_t;

  localparam logic [2:0] RQ_NONE     = 3'd0;
  localparam logic [2:0] RQ_UP_PRESS = 3'd1;
  localparam logic [2:0] RQ_DN_PRESS = 3'd2;
  localparam logic [2:0] RQ_UP_AUTO  = 3'd3;
  localparam logic [2:0] RQ_DN_AUTO  = 3'd4;
  localparam logic [2:0] RQ_UP_STOP  = 3'd5;
  localparam logic [2:0] RQ_DN_STOP  = 3'd6;

  localparam logic [2:0] WM_IDLE   = 3'd0;
  localparam logic [2:0] WM_MDOWN  = 3'd1;
  localparam logic [2:0] WM_MUP    = 3'd2;
  localparam logic [2:0] WM_ADOWN  = 3'd3;
  localparam logic [2:0] WM_AUP    = 3'd4;
  localparam logic [2:0] WM_BLOCK  = 3'd5;
  localparam logic [2:0] WM_CCLOSE = 3'd6;
  localparam logic [2:0] WM_AOFF   = 3'd7;

  localparam logic [1:0] AM_REL = 2'd0;
  localparam logic [1:0] AM_ARM = 2'd1;
  localparam logic [1:0] AM_OVR = 2'd2;

  localparam int T_AUTH = 0;
  localparam int T_HOLD = 1;
  localparam int T_OUT  = 2;
  localparam int T_IN   = 3;

  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_HOLD   = 2'd1;
  localparam logic [1:0] REG_AUTH   = 2'd2;
  localparam logic [1:0] REG_STEP   = 2'd3;

endpackage

### sv/otwl_regs.sv
// APB configuration register file for the window lift controller.
module otwl_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] filter_lim,
  output logic [15:0] hold_lim,
  output logic [15:0] auth_lim,
  output logic [15:0] step_lim
);
  import otwl_pkg::*;

  logic [1:0] idx;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_lim <= 16'd20;
      hold_lim   <= 16'd500;
      auth_lim   <= 16'd10000;
      step_lim   <= 16'd100;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_FILTER: filter_lim <= pwdata[15:0];
        REG_HOLD:   hold_lim   <= pwdata[15:0];
        REG_AUTH:   auth_lim   <= pwdata[15:0];
        REG_STEP:   step_lim   <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FILTER: prdata = {16'd0, filter_lim};
      REG_HOLD:   prdata = {16'd0, hold_lim};
      REG_AUTH:   prdata = {16'd0, auth_lim};
      REG_STEP:   prdata = {16'd0, step_lim};
      default:    prdata = 32'd0;
    endcase
  end
endmodule

### sv/one_touch_window_lift_controller.sv
// Top level of the one-touch window lift controller.
// Each accepted transaction is one control pass: timers, input filter, window,
// authorization and sequencer state all update from the input register when the
// pass goes ahead, and the result lands in an output register. One transaction
// is taken every cycle; a waiting result stalls input only when the output
// register is full and not being drained. Timer width follows TIMER_WIDTH
// (8..32); limits are 16-bit APB registers at byte offsets 0, 4, 8, 12.
module one_touch_window_lift_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  otwl_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output otwl_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import otwl_pkg::*;

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [15:0] filter_lim, hold_lim, auth_lim, step_lim;

  otwl_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .filter_lim, .hold_lim, .auth_lim, .step_lim
  );

  // input register
  logic     iv;
  in_item_t ir;
  logic     go;

  assign go       = iv && (!out_valid || out_ready);
  assign in_ready = !iv || go;

  always_ff @(posedge clk) begin
    if (rst) iv <= 1'b0;
    else if (in_ready) iv <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) ir <= in_data;
  end

  // state
  logic [2:0] window_state, window_state_next;
  logic [1:0] ovr_state, ovr_state_next;
  logic [1:0] seq_state, seq_state_next;
  logic [TIMER_WIDTH-1:0] timer_counts [4];
  logic [TIMER_WIDTH-1:0] timer_counts_next [4];
  logic [3:0] timer_enables, timer_enables_next;
  logic [3:0] timer_rollovers, timer_rollovers_next;
  logic [5:0] filtered_inputs, filtered_inputs_next;
  logic [5:0] last_samples, last_samples_next;
  logic [2:0] request_mailbox, request_mailbox_next;
  logic [2:0] cached_request, cached_request_next;
  logic [2:0] handshake_flags, handshake_flags_next;
  logic [2:0] drive_levels, drive_levels_next;

  logic [15:0] lim [4];
  assign lim[T_AUTH] = auth_lim;
  assign lim[T_HOLD] = hold_lim;
  assign lim[T_OUT]  = step_lim;
  assign lim[T_IN]   = filter_lim;

  always_comb begin
    logic [TIMER_WIDTH-1:0] c [4];
    logic [3:0] en, ro;
    logic [5:0] fi, ls, raw, match;
    logic [2:0] ws, mb, cr, hs, dl;
    logic [1:0] as, ss;
    logic u, d, ur, dr, cc, ccov, hroll, up_only, dn_only, both, none, neither;
    logic mism, is_up, am, keep, ain, aon, aoff, aroll, vld, oroll;
    logic [2:0] stop, autoq;
    logic [CW-1:0] cx;
    logic [CW-1:0] lx;

    en = timer_enables; ro = timer_rollovers;
    fi = filtered_inputs; ls = last_samples;
    ws = window_state; as = ovr_state; ss = seq_state;
    mb = request_mailbox; cr = cached_request; hs = handshake_flags;
    dl = drive_levels;
    match = '0; cx = '0; lx = '0;
    for (int t = 0; t < 4; t++) begin
      c[t] = timer_counts[t];
      if (ir.tick && en[t]) begin
        c[t] = c[t] + 1'b1;
        cx = CW'(c[t]);
        lx = CW'(lim[t]);
        if (cx >= lx) ro[t] = 1'b1;
      end
    end

    // input filter
    raw = {ir.auth_level, ir.close_req, ir.down_remote, ir.up_remote,
           ir.down_local, ir.up_local};
    if (ro[T_IN]) begin
      match = ~(raw ^ ls);
      fi = (fi & ~match) | (raw & match);
      ls = raw;
      c[T_IN] = '0; ro[T_IN] = 1'b0; en[T_IN] = 1'b1;
    end

    // window FSM
    u = fi[0]; d = fi[1]; ur = fi[2]; dr = fi[3]; cc = fi[4];
    ccov = hs[0]; hroll = ro[T_HOLD];
    up_only = (u && !d) || (ur && !dr);
    dn_only = (!u && d) || (!ur && dr);
    both    = (u && d) || (ur && dr);
    none    = !u && !d && !ur && !dr;
    neither = (!u && !d) || (!ur && !dr);
    mism    = (u && dr) || (ur && d);
    is_up   = (ws == WM_MUP) || (ws == WM_AUP);
    stop    = is_up ? RQ_UP_STOP : RQ_DN_STOP;
    autoq   = is_up ? RQ_UP_AUTO : RQ_DN_AUTO;
    am = is_up ? ((u && d && dr && !ur) || (ur && dr && d && !u))
               : ((u && d && !dr && ur) || (ur && dr && !d && u));
    keep = is_up ? (u || ur) : (d || dr);
    hs[0] = 1'b0; ro[T_HOLD] = 1'b0;
    case (ws)
      WM_MDOWN, WM_MUP: begin
        if (mism) begin
          en[T_HOLD] = 1'b0; mb = stop; ws = WM_BLOCK;
        end else if (is_up ? up_only : dn_only) begin
        end else if (none) begin
          en[T_HOLD] = 1'b0; mb = hroll ? stop : autoq; ws = WM_IDLE;
        end else if (both) begin
          en[T_HOLD] = 1'b0; ws = is_up ? WM_AUP : WM_ADOWN;
        end else begin
          en[T_HOLD] = 1'b0; mb = stop; ws = WM_BLOCK;
        end
      end
      WM_ADOWN, WM_AUP: begin
        if (am) begin
          en[T_HOLD] = 1'b0; mb = stop; ws = WM_BLOCK;
        end else if (keep) begin
        end else if (neither) begin
          mb = autoq; ws = WM_IDLE;
        end else begin
          en[T_HOLD] = 1'b0; mb = stop; ws = WM_BLOCK;
        end
      end
      WM_BLOCK: begin
        en[T_HOLD] = 1'b0;
        ws = none ? WM_IDLE : WM_BLOCK;
      end
      WM_CCLOSE: begin
        mb = RQ_UP_AUTO; ws = WM_AOFF;
      end
      WM_AOFF: begin
        if (ccov && !cc) begin
          hs[1] = 1'b0; hs[2] = 1'b1; ws = WM_IDLE;
        end
      end
      default: begin
        if (none && !cc) en[T_HOLD] = 1'b0;
        else if (none) begin
          hs[2] = 1'b0; hs[1] = 1'b1; mb = RQ_UP_PRESS; ws = WM_CCLOSE;
        end else if (up_only || dn_only) begin
          c[T_HOLD] = '0; ro[T_HOLD] = 1'b0; en[T_HOLD] = 1'b1;
          mb = up_only ? RQ_UP_PRESS : RQ_DN_PRESS;
          ws = up_only ? WM_MUP : WM_MDOWN;
        end else begin
          en[T_HOLD] = 1'b0; mb = RQ_NONE; ws = WM_BLOCK;
        end
      end
    endcase

    // authorization FSM
    ain = fi[5]; aon = hs[1]; aoff = hs[2]; aroll = ro[T_AUTH];
    case (as)
      AM_ARM: begin
        dl[2] = 1'b1;
        if (!ain) begin
          c[T_AUTH] = '0; ro[T_AUTH] = 1'b0; en[T_AUTH] = 1'b1; as = AM_OVR;
        end
      end
      AM_OVR: begin
        if (ain) begin
          dl[2] = 1'b1; en[T_AUTH] = 1'b0; as = AM_ARM;
        end else if (aon) begin
          dl[2] = 1'b1; c[T_AUTH] = '0; ro[T_AUTH] = 1'b0; en[T_AUTH] = 1'b1;
        end else if (aroll || aoff) begin
          dl[2] = 1'b0; en[T_AUTH] = 1'b0; as = AM_REL;
        end else dl[2] = 1'b1;
      end
      default: begin
        if (ain) begin
          dl[2] = 1'b1; as = AM_ARM;
        end else if (aon) begin
          dl[2] = 1'b1; c[T_AUTH] = '0; ro[T_AUTH] = 1'b0; en[T_AUTH] = 1'b1;
          as = AM_OVR;
        end else begin
          dl[2] = 1'b0; as = AM_REL;
        end
      end
    endcase
    hs[2:1] = 2'b00; ro[T_AUTH] = 1'b0;

    // sequencer
    vld = (cr >= RQ_UP_PRESS) && (cr <= RQ_DN_STOP);
    oroll = ro[T_OUT];
    case (ss)
      2'd1: begin
        if (!vld) begin
          en[T_OUT] = 1'b0; ss = 2'd0;
        end else if (oroll) begin
          en[T_OUT] = 1'b0; ss = 2'd2;
        end
      end
      2'd2: begin
        if (!vld) ss = 2'd0;
        else begin
          case (cr)
            RQ_UP_PRESS:            dl[1] = 1'b1;
            RQ_DN_PRESS:            dl[0] = 1'b1;
            RQ_UP_AUTO, RQ_DN_STOP: dl[0] = 1'b0;
            default:                dl[1] = 1'b0;
          endcase
          c[T_OUT] = '0; ro[T_OUT] = 1'b0; en[T_OUT] = 1'b1; ss = 2'd3;
        end
      end
      2'd3: begin
        if (!vld || oroll) begin
          en[T_OUT] = 1'b0; ss = 2'd0;
        end
      end
      default: begin
        cr = mb; mb = RQ_NONE; hs[0] = 1'b1;
        if ((cr >= RQ_UP_PRESS) && (cr <= RQ_DN_STOP)) begin
          case (cr)
            RQ_UP_PRESS: dl[0] = 1'b1;
            RQ_DN_PRESS: dl[1] = 1'b1;
            RQ_UP_AUTO: begin
              dl[1] = 1'b0; hs[0] = 1'b0;
            end
            RQ_DN_AUTO, RQ_UP_STOP: dl[0] = 1'b0;
            default: dl[1] = 1'b0;
          endcase
          c[T_OUT] = '0; ro[T_OUT] = 1'b0; en[T_OUT] = 1'b1; ss = 2'd1;
        end else ss = 2'd0;
      end
    endcase

    for (int t = 0; t < 4; t++) timer_counts_next[t] = c[t];
    timer_enables_next = en; timer_rollovers_next = ro;
    filtered_inputs_next = fi; last_samples_next = ls;
    window_state_next = ws; ovr_state_next = as; seq_state_next = ss;
    request_mailbox_next = mb; cached_request_next = cr;
    handshake_flags_next = hs; drive_levels_next = dl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_state <= WM_IDLE; ovr_state <= AM_REL; seq_state <= 2'd0;
      for (int t = 0; t < 4; t++) timer_counts[t] <= '0;
      timer_enables <= 4'b1000; timer_rollovers <= '0;
      filtered_inputs <= '0; last_samples <= '0;
      request_mailbox <= RQ_NONE; cached_request <= RQ_NONE;
      handshake_flags <= '0; drive_levels <= '0;
    end else if (go) begin
      window_state <= window_state_next; ovr_state <= ovr_state_next;
      seq_state <= seq_state_next;
      for (int t = 0; t < 4; t++) timer_counts[t] <= timer_counts_next[t];
      timer_enables <= timer_enables_next; timer_rollovers <= timer_rollovers_next;
      filtered_inputs <= filtered_inputs_next; last_samples <= last_samples_next;
      request_mailbox <= request_mailbox_next; cached_request <= cached_request_next;
      handshake_flags <= handshake_flags_next; drive_levels <= drive_levels_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (go) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (go) begin
      out_data.up_drive       <= drive_levels_next[0];
      out_data.down_drive     <= drive_levels_next[1];
      out_data.auth_drive     <= drive_levels_next[2];
      out_data.window_mode    <= window_state_next;
      out_data.auth_mode      <= ovr_state_next;
      out_data.sequence_phase <= seq_state_next;
    end
  end

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    ovr_state != 2'd3) else $error("auth state out of range");
  a_auth_drive: assert property (@(posedge clk) disable iff (rst)
    (ovr_state == AM_ARM || ovr_state == AM_OVR) |-> drive_levels[2])
    else $error("override state without auth drive");
  a_hold_quiet: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(window_state)) else $error("window state moved without a pass");
  a_no_result_without_pass: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !go) |=> out_valid)
    else $error("result dropped");
endmodule

### sim/one_touch_window_lift_controller_tb.sv
// Testbench for the one-touch window lift controller: random and directed control passes.
module one_touch_window_lift_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import otwl_pkg::*;

  // Behavioral copy of the controller; checks each drive result in order.
  class lift_scoreboard;
    logic [15:0] lim [4];
    logic [2:0]  win_st;
    logic [1:0]  auth_st, seq_st;
    logic [15:0] cnt [4];
    logic [3:0]  ten, troll;
    logic [5:0]  filt, last;
    logic [2:0]  mbox, cached;
    logic        hs_ccover, hs_aon, hs_aoff;
    logic        dr_up, dr_dn, dr_auth;
    out_item_t   pending [$];
    int          mismatches;
    int          checked;

    function new();
      lim[REG_FILTER] = 16'd20;
      lim[REG_HOLD] = 16'd500;
      lim[REG_AUTH] = 16'd10000;
      lim[REG_STEP] = 16'd100;
      win_st = WM_IDLE;
      auth_st = AM_REL;
      seq_st = 2'd0;
      foreach (cnt[i]) cnt[i] = '0;
      ten = 4'b1000;
      troll = '0;
      filt = '0;
      last = '0;
      mbox = RQ_NONE;
      cached = RQ_NONE;
      {hs_ccover, hs_aon, hs_aoff} = '0;
      {dr_up, dr_dn, dr_auth} = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_limit(int idx, logic [15:0] v);
      lim[idx] = v;
    endfunction

    function logic [15:0] limit_of(int t);
      case (t)
        T_AUTH: return lim[REG_AUTH];
        T_HOLD: return lim[REG_HOLD];
        T_OUT:  return lim[REG_STEP];
        default: return lim[REG_FILTER];
      endcase
    endfunction

    function void tstart(int t);
      cnt[t] = '0;
      troll[t] = 1'b0;
      ten[t] = 1'b1;
    endfunction

    function void tstop(int t);
      ten[t] = 1'b0;
    endfunction

    function void window_pass();
      logic u, d, ur, dr, cc, cc_over, hold_roll;
      logic up_only, dn_only, both, none, neither, mism, is_up, am, keep;
      logic [2:0] stop_rq, auto_rq;
      u = filt[0]; d = filt[1]; ur = filt[2]; dr = filt[3]; cc = filt[4];
      cc_over = hs_ccover;
      hold_roll = troll[T_HOLD];
      up_only = (u && !d) || (ur && !dr);
      dn_only = (!u && d) || (!ur && dr);
      both = (u && d) || (ur && dr);
      none = !u && !d && !ur && !dr;
      neither = (!u && !d) || (!ur && !dr);
      mism = (u && dr) || (ur && d);
      is_up = (win_st == WM_MUP) || (win_st == WM_AUP);
      stop_rq = is_up ? RQ_UP_STOP : RQ_DN_STOP;
      auto_rq = is_up ? RQ_UP_AUTO : RQ_DN_AUTO;
      hs_ccover = 1'b0;
      troll[T_HOLD] = 1'b0;
      case (win_st)
        WM_MDOWN, WM_MUP: begin
          if (mism) begin
            tstop(T_HOLD); mbox = stop_rq; win_st = WM_BLOCK;
          end else if (is_up ? up_only : dn_only) begin
          end else if (none) begin
            tstop(T_HOLD);
            mbox = hold_roll ? stop_rq : auto_rq;
            win_st = WM_IDLE;
          end else if (both) begin
            tstop(T_HOLD); win_st = is_up ? WM_AUP : WM_ADOWN;
          end else begin
            tstop(T_HOLD); mbox = stop_rq; win_st = WM_BLOCK;
          end
        end
        WM_ADOWN, WM_AUP: begin
          am = is_up ? ((u && d && dr && !ur) || (ur && dr && d && !u))
                     : ((u && d && !dr && ur) || (ur && dr && !d && u));
          keep = is_up ? (u || ur) : (d || dr);
          if (am) begin
            tstop(T_HOLD); mbox = stop_rq; win_st = WM_BLOCK;
          end else if (keep) begin
          end else if (neither) begin
            mbox = auto_rq; win_st = WM_IDLE;
          end else begin
            tstop(T_HOLD); mbox = stop_rq; win_st = WM_BLOCK;
          end
        end
        WM_BLOCK: begin
          tstop(T_HOLD);
          win_st = none ? WM_IDLE : WM_BLOCK;
        end
        WM_CCLOSE: begin
          mbox = RQ_UP_AUTO; win_st = WM_AOFF;
        end
        WM_AOFF: begin
          if (cc_over && !cc) begin
            hs_aon = 1'b0; hs_aoff = 1'b1; win_st = WM_IDLE;
          end
        end
        default: begin
          if (none && !cc) tstop(T_HOLD);
          else if (none) begin
            hs_aoff = 1'b0; hs_aon = 1'b1; mbox = RQ_UP_PRESS; win_st = WM_CCLOSE;
          end else if (up_only) begin
            tstart(T_HOLD); mbox = RQ_UP_PRESS; win_st = WM_MUP;
          end else if (dn_only) begin
            tstart(T_HOLD); mbox = RQ_DN_PRESS; win_st = WM_MDOWN;
          end else begin
            tstop(T_HOLD); mbox = RQ_NONE; win_st = WM_BLOCK;
          end
        end
      endcase
    endfunction

    function void auth_pass();
      logic ain, roll;
      ain = filt[5];
      roll = troll[T_AUTH];
      case (auth_st)
        AM_ARM: begin
          dr_auth = 1'b1;
          if (!ain) begin
            tstart(T_AUTH); auth_st = AM_OVR;
          end
        end
        AM_OVR: begin
          if (ain) begin
            dr_auth = 1'b1; tstop(T_AUTH); auth_st = AM_ARM;
          end else if (hs_aon) begin
            dr_auth = 1'b1; tstart(T_AUTH);
          end else if (roll || hs_aoff) begin
            dr_auth = 1'b0; tstop(T_AUTH); auth_st = AM_REL;
          end else dr_auth = 1'b1;
        end
        default: begin
          if (ain) begin
            dr_auth = 1'b1; auth_st = AM_ARM;
          end else if (hs_aon) begin
            dr_auth = 1'b1; tstart(T_AUTH); auth_st = AM_OVR;
          end else begin
            dr_auth = 1'b0; auth_st = AM_REL;
          end
        end
      endcase
      hs_aon = 1'b0;
      hs_aoff = 1'b0;
      troll[T_AUTH] = 1'b0;
    endfunction

    function void sequence_pass();
      logic ok, roll;
      ok = cached >= RQ_UP_PRESS && cached <= RQ_DN_STOP;
      roll = troll[T_OUT];
      case (seq_st)
        2'd1: begin
          if (!ok) begin
            tstop(T_OUT); seq_st = 2'd0;
          end else if (roll) begin
            tstop(T_OUT); seq_st = 2'd2;
          end
        end
        2'd2: begin
          if (!ok) seq_st = 2'd0;
          else begin
            case (cached)
              RQ_UP_PRESS: dr_dn = 1'b1;
              RQ_DN_PRESS: dr_up = 1'b1;
              RQ_UP_AUTO, RQ_DN_STOP: dr_up = 1'b0;
              default: dr_dn = 1'b0;
            endcase
            tstart(T_OUT);
            seq_st = 2'd3;
          end
        end
        2'd3: begin
          if (!ok || roll) begin
            tstop(T_OUT); seq_st = 2'd0;
          end
        end
        default: begin
          cached = mbox;
          mbox = RQ_NONE;
          hs_ccover = 1'b1;
          if (!(cached >= RQ_UP_PRESS && cached <= RQ_DN_STOP)) seq_st = 2'd0;
          else begin
            case (cached)
              RQ_UP_PRESS: dr_up = 1'b1;
              RQ_DN_PRESS: dr_dn = 1'b1;
              RQ_UP_AUTO: begin
                dr_dn = 1'b0; hs_ccover = 1'b0;
              end
              RQ_DN_AUTO, RQ_UP_STOP: dr_up = 1'b0;
              default: dr_dn = 1'b0;
            endcase
            tstart(T_OUT);
            seq_st = 2'd1;
          end
        end
      endcase
    endfunction

    // Run one control pass for an accepted input and queue its drive result.
    function void note_pass(in_item_t it);
      logic [5:0] raw, match;
      out_item_t r;
      if (it.tick) begin
        for (int t = 0; t < 4; t++) begin
          if (ten[t]) begin
            cnt[t] = cnt[t] + 16'd1;
            if (cnt[t] >= limit_of(t)) troll[t] = 1'b1;
          end
        end
      end
      if (troll[T_IN]) begin
        raw = {it.auth_level, it.close_req, it.down_remote, it.up_remote,
               it.down_local, it.up_local};
        match = ~(raw ^ last);
        filt = (filt & ~match) | (raw & match);
        last = raw;
        tstart(T_IN);
      end
      window_pass();
      auth_pass();
      sequence_pass();
      r.up_drive = dr_up;
      r.down_drive = dr_dn;
      r.auth_drive = dr_auth;
      r.window_mode = win_st;
      r.auth_mode = auth_st;
      r.sequence_phase = seq_st;
      pending.push_back(r);
    endfunction

    function void check_drive(out_item_t got);
      out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lift_scoreboard lift;
  int cycles = 0;
  int sent = 0;
  bit stall_long = 0;
  bit sink_on = 0;
  localparam int CYCLE_LIMIT = 400000;

  one_touch_window_lift_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) lift.check_drive(out_data);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int w;
    wait (sink_on);
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        stall_long = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 4) == 0) w = 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lift.set_limit(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Valid stays up into the next call when there is no gap; drain drops it.
  task automatic send_pass(input in_item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    lift.note_pass(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (lift.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_item_t buttons(int kind);
    in_item_t it;
    it = '0;
    it.tick = 1'b1;
    case (kind)
      0: it.up_local = 1'b1;
      1: it.down_local = 1'b1;
      2: it.up_remote = 1'b1;
      3: it.down_remote = 1'b1;
      4: {it.up_local, it.down_local} = 2'b11;
      5: {it.up_local, it.down_remote} = 2'b11;
      6: it.close_req = 1'b1;
      default: ;
    endcase
    it.auth_level = ($urandom_range(0, 5) == 0);
    return it;
  endfunction

  // Hold one button pattern for len passes, mostly ticking.
  task automatic press(int kind, int len, bit fast);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it = buttons(kind);
      if ($urandom_range(0, 7) == 0) it.tick = 1'b0;
      if ($urandom_range(0, 30) == 0) it = in_item_t'(7'($urandom()));
      send_pass(it, fast ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0));
    end
  endtask

  initial begin
    lift = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sink_on = 1;
    // directed: small limits, then every button pattern for short presses
    reg_write(REG_FILTER, 16'd1);
    reg_write(REG_HOLD, 16'd3);
    reg_write(REG_AUTH, 16'd4);
    reg_write(REG_STEP, 16'd1);
    send_pass('0, 0);
    send_pass('1, 0);
    for (int k = 0; k < 8; k++) press(k, 3, 1'b1);
    drain();
    // fill the result side while sending back to back
    stall_long = 1;
    press(0, 30, 1'b1);
    press(7, 10, 1'b1);
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_FILTER, 16'd1); reg_write(REG_HOLD, 16'd1);
          reg_write(REG_AUTH, 16'd1); reg_write(REG_STEP, 16'd1);
        end
        1: begin
          reg_write(REG_FILTER, 16'd2); reg_write(REG_HOLD, 16'd8);
          reg_write(REG_AUTH, 16'd20); reg_write(REG_STEP, 16'd3);
        end
        2: begin
          reg_write(REG_FILTER, 16'hFFFF); reg_write(REG_HOLD, 16'hFFFF);
          reg_write(REG_AUTH, 16'hFFFF); reg_write(REG_STEP, 16'hFFFF);
        end
        3: begin
          reg_write(REG_FILTER, 16'd0); reg_write(REG_HOLD, 16'd0);
          reg_write(REG_AUTH, 16'd0); reg_write(REG_STEP, 16'd0);
        end
        default: begin
          reg_write(REG_FILTER, 16'd1); reg_write(REG_HOLD, 16'd5);
          reg_write(REG_AUTH, 16'd12); reg_write(REG_STEP, 16'd2);
        end
      endcase
      while (sent < 150 + (phase + 1) * 280) begin
        if ($urandom_range(0, 9) < 7)
          press($urandom_range(0, 7), $urandom_range(1, 14), $urandom_range(0, 3) == 0);
        else
          send_pass(in_item_t'(7'($urandom())), $urandom_range(0, 11));
      end
      drain();
    end
    drain();
    $display("covered %0d passes, %0d results checked, five limit settings incl. 0 and max",
             sent, lift.checked);
    if (lift.mismatches == 0 && lift.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d left over", lift.mismatches, lift.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
sv/otwl_pkg.sv
sv/otwl_regs.sv
sv/one_touch_window_lift_controller.sv
sim/one_touch_window_lift_controller_tb.sv
